@@ sv/sequence_reorder_receiver_top_assert.svh @@
// assertion macros for the sequence reorder receiver
`ifndef SEQUENCE_REORDER_RECEIVER_TOP_ASSERT_SVH
`define SEQUENCE_REORDER_RECEIVER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SRR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/srr_pkg.sv @@
// types and constants shared by the sequence reorder receiver
`default_nettype none

package srr_pkg;

	localparam int unsigned MIN_LEN = 6;
	localparam int unsigned HDR_LEN = 5;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_SHORT   = 2'd2,
		KIND_BEYOND  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DRAIN,
		ST_ACK
	} state_t;

	typedef struct packed {
		logic [10:0] packet_length;
		logic [31:0] seq;
		logic        fin;
		logic [15:0] payload_tag;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] part_seq;
		logic [15:0] part_tag;
		logic [10:0] part_length;
		logic        end_of_message;
		logic        last;
	} out_t;

	// one stored out-of-order part
	typedef struct packed {
		logic [15:0] tag;
		logic [10:0] length;
		logic        eom;
	} slot_t;

endpackage

`default_nettype wire

@@ sv/sequence_reorder_receiver_top.sv @@
// selective-repeat receiver: in-order delivery, window store, acks and drops
`default_nettype none

// Usage
// - input channel: drive item and raise start; the word is taken at a clock edge
//   where start is high and busy is low. busy stays high until the item's last
//   result word has been issued
// - output channel: each result word sits on result for one cycle with strobe
//   high; result.last marks the final word caused by an input. the receiver
//   cannot stall this channel, so every strobe cycle must be consumed
// - the accepting edge enters the decide state, whose first result word is then registered onto result
// - a short, beyond-window, early or stored packet passes through the decide state only;
//   an in-order packet passes through decide and ack, plus the drain state for any
//   stored successors it releases. the drain is paced by the single read port of the
//   slot memory, with reads issued back to back, each in the cycle before the drain emits it
// - reset: expected sequence number 1, all slot valid bits cleared, no strobe.
//   slot payload memory is not cleared; a slot is read only while its valid bit
//   is set, so no clearing pass is needed
// - slot index tracks expected_seq mod WINDOW incrementally, so no divider is used
module sequence_reorder_receiver_top #(
	parameter int unsigned WINDOW = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire srr_pkg::in_t item,
	output logic              strobe,
	output srr_pkg::out_t     result
);

	import srr_pkg::*;

	localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SW = IW + 1;
	localparam logic [IW-1:0] SLOT_MAX = IW'(WINDOW - 1);
	localparam logic [SW-1:0] WIN_S = SW'(WINDOW);
	localparam logic [31:0] WIN_W = 32'(WINDOW);

	// next slot index with wrap at the window size
	function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
		logic [IW-1:0] r;
		if (s == SLOT_MAX) begin
			r = '0;
		end else begin
			r = s + IW'(1);
		end
		return r;
	endfunction

	// control and state registers
	state_t        state_q, state_d;
	logic [31:0]   exp_q, exp_d;
	logic [IW-1:0] exp_slot_q, exp_slot_d;
	logic [WINDOW-1:0] valid_q;

	// accepted item and precomputed compares against expected_seq
	in_t           item_q;
	logic [31:0]   diff_q;
	logic          gt_q;
	logic          eq_q;

	// slot memory and its registered read port
	slot_t         slot_mem_q [WINDOW];
	slot_t         rd_slot_s1;
	logic [31:0]   rd_seq_s1;
	logic [31:0]   rd_seq_d;

	// memory and valid bit controls
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	slot_t         wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	// output register
	out_t          result_q, result_d;
	logic          strobe_q, strobe_d;

	// helper values for the decide state
	logic          accept;
	logic          is_short;
	logic          is_beyond;
	logic [SW-1:0] slot_sum;
	logic [IW-1:0] store_slot;
	logic [IW-1:0] next_slot;
	logic [IW-1:0] next_slot2;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	assign is_short  = (item_q.packet_length < 11'(MIN_LEN));
	assign is_beyond = gt_q && (diff_q > WIN_W);

	// later packet lands at (exp_slot + distance) mod WINDOW, distance in 1..WINDOW
	assign slot_sum   = {1'b0, exp_slot_q} + diff_q[SW-1:0];
	assign store_slot = (slot_sum >= WIN_S) ? IW'(slot_sum - WIN_S) : IW'(slot_sum);
	assign next_slot  = slot_inc(exp_slot_q);
	assign next_slot2 = slot_inc(next_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			exp_q      <= 32'd1;
			exp_slot_q <= IW'(1 % WINDOW);
			valid_q    <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			exp_q      <= exp_d;
			exp_slot_q <= exp_slot_d;
			strobe_q   <= strobe_d;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				valid_q[rd_addr] <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			diff_q <= item.seq - exp_q;
			gt_q   <= (item.seq > exp_q);
			eq_q   <= (item.seq == exp_q);
		end
		result_q <= result_d;
		if (rd_en) begin
			rd_seq_s1 <= rd_seq_d;
		end
	end

	// slot memory, one write and one read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_slot_s1 <= slot_mem_q[rd_addr];
		end
	end

	always_comb begin
		state_d    = state_q;
		exp_d      = exp_q;
		exp_slot_d = exp_slot_q;
		strobe_d   = 1'b0;
		result_d   = '0;
		wr_en      = 1'b0;
		wr_addr    = store_slot;
		wr_data    = '{tag: item_q.payload_tag,
			length: item_q.packet_length - 11'(HDR_LEN), eom: item_q.fin};
		rd_en      = 1'b0;
		rd_addr    = exp_slot_q;
		rd_seq_d   = exp_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECIDE;
				end
			end

			ST_DECIDE: begin
				strobe_d = 1'b1;
				priority if (is_short) begin
					result_d.kind = KIND_SHORT;
					result_d.last = 1'b1;
					state_d       = ST_IDLE;
				end else if (is_beyond) begin
					result_d.kind     = KIND_BEYOND;
					result_d.part_seq = item_q.seq;
					result_d.last     = 1'b1;
					state_d           = ST_IDLE;
				end else if (eq_q) begin
					// deliver now, then look at the successor's slot
					result_d.kind           = KIND_DELIVER;
					result_d.part_seq       = item_q.seq;
					result_d.part_tag       = item_q.payload_tag;
					result_d.part_length    = item_q.packet_length - 11'(HDR_LEN);
					result_d.end_of_message = item_q.fin;
					if (valid_q[next_slot]) begin
						rd_en      = 1'b1;
						rd_addr    = next_slot;
						rd_seq_d   = exp_q + 32'd1;
						exp_d      = exp_q + 32'd2;
						exp_slot_d = next_slot2;
						state_d    = ST_DRAIN;
					end else begin
						exp_d      = exp_q + 32'd1;
						exp_slot_d = next_slot;
						state_d    = ST_ACK;
					end
				end else begin
					// later packet stored once, earlier duplicate only acked
					if (gt_q && !valid_q[store_slot]) begin
						wr_en = 1'b1;
					end
					result_d.kind     = KIND_ACK;
					result_d.part_seq = item_q.seq;
					result_d.last     = 1'b1;
					state_d           = ST_IDLE;
				end
			end

			ST_DRAIN: begin
				// emit the slot read last cycle, issue the next read if present
				strobe_d                = 1'b1;
				result_d.kind           = KIND_DELIVER;
				result_d.part_seq       = rd_seq_s1;
				result_d.part_tag       = rd_slot_s1.tag;
				result_d.part_length    = rd_slot_s1.length;
				result_d.end_of_message = rd_slot_s1.eom;
				if (valid_q[exp_slot_q]) begin
					rd_en      = 1'b1;
					rd_addr    = exp_slot_q;
					rd_seq_d   = exp_q;
					exp_d      = exp_q + 32'd1;
					exp_slot_d = next_slot;
				end else begin
					state_d = ST_ACK;
				end
			end

			ST_ACK: begin
				strobe_d          = 1'b1;
				result_d.kind     = KIND_ACK;
				result_d.part_seq = item_q.seq;
				result_d.last     = 1'b1;
				state_d           = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`include "sequence_reorder_receiver_top_assert.svh"

	// an accepted word keeps the block busy until its results are out
	`SRR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	// the final word of an input is never followed directly by another word
	`SRR_ASSERT_NEXT(a_last_gap, strobe && result.last, !strobe, "word right after last")
	// only deliveries can be followed by more words of the same input
	`SRR_ASSERT_SAME(a_nondeliver_last, strobe && (result.kind != KIND_DELIVER),
		result.last, "ack or drop word without last")
	// a word that is not last means the block is still working on the input
	`SRR_ASSERT_SAME(a_more_busy, strobe && !result.last, busy, "idle with results pending")

endmodule

`default_nettype wire
